// ----- design/radar_target_frame_parser_macros.svh -----
// Assertion macros shared by the radar target frame parser checker.
`ifndef RADAR_TARGET_FRAME_PARSER_MACROS_SVH
`define RADAR_TARGET_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rtfp_pkg.sv -----
// Types and constants of the radar target frame parser.
`default_nettype none

package rtfp_pkg;

    // Header sequence length and field geometry
    localparam int HDR_LEN     = 4;
    localparam int HDR_CNT_W   = 3;
    localparam int FIELD_W     = 16;
    localparam int OUT_SLOTS   = 3;
    localparam int SLOT_W      = 3 * FIELD_W;
    localparam int VCNT_W      = 2;
    localparam int VCNT_OFS    = OUT_SLOTS * SLOT_W;
    localparam int M_TDATA_W   = ((VCNT_OFS + VCNT_W + 7) / 8) * 8;
    localparam int S_TDATA_W   = 8;

    localparam logic [HDR_CNT_W-1:0] HDR_DONE = HDR_CNT_W'(HDR_LEN);

    // One decoded target
    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] speed;
    } target_t;

    // Expected header byte at each match position
    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'hAA;
            2'd1:    b = 8'hFF;
            2'd2:    b = 8'h03;
            2'd3:    b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/rtfp_target_decode.sv -----
// Validity check and sign-magnitude decode of one target record.
`default_nettype none

module rtfp_target_decode (
    input  wire logic [rtfp_pkg::FIELD_W-1:0] x_raw,
    input  wire logic [rtfp_pkg::FIELD_W-1:0] y_raw,
    input  wire logic [rtfp_pkg::FIELD_W-1:0] speed_raw,
    output rtfp_pkg::target_t                 target,
    output logic                              ok
);

    // Bit 15 set is positive, clear is negative; magnitude in the low bits
    function automatic logic [rtfp_pkg::FIELD_W-1:0] sm_decode(
        input logic [rtfp_pkg::FIELD_W-1:0] raw
    );
        logic [rtfp_pkg::FIELD_W-1:0] mag;
        mag = {1'b0, raw[rtfp_pkg::FIELD_W-2:0]};
        return raw[rtfp_pkg::FIELD_W-1] ? mag : (~mag + 1'b1);
    endfunction

    assign ok = (x_raw != '0) && (y_raw != '0);

    // Invalid targets pass raw words through
    always_comb begin
        if (ok) begin
            target.x     = sm_decode(x_raw);
            target.y     = sm_decode(y_raw);
            target.speed = sm_decode(speed_raw);
        end else begin
            target.x     = x_raw;
            target.y     = y_raw;
            target.speed = speed_raw;
        end
    end

endmodule

`default_nettype wire

// ----- design/radar_target_frame_parser.sv -----
// Radar target frame parser: header hunt, payload capture and target decode.
//
// Input channel s_*: one serial byte per item on s_tdata[7:0].
// Output channel m_*: one item per completed frame carrying three decoded
// targets and the count of valid targets.
// The parser hunts for the header AA FF 03 00 (a mismatch clears the match
// and the byte is not rechecked), then collects TARGET_SLOTS * RECORD_BYTES
// payload bytes in a shift line. On the last payload byte the whole frame is
// decoded in the same cycle and written to the output register.
// Throughput: one byte per cycle, save for the stall below. Latency: the result item is
// valid in the cycle after the last payload byte is accepted. The rate is set by
// the single decode pass between the byte shift line and the output register.
// Stall: while a result waits on m_tready, header and payload bytes keep being
// accepted; only the last payload byte of the next frame is held off until
// the waiting result has been taken.
// Reset: aresetn low clears the header and payload counters and drops
// m_tvalid; the payload shift line is not cleared, as every byte of it is
// rewritten before a frame is decoded.
`default_nettype none

module radar_target_frame_parser #(
    parameter int TARGET_SLOTS = 3,
    parameter int RECORD_BYTES = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: [7:0] rx_byte
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rtfp_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: [15:0] t0_x_mm, [31:16] t0_y_mm, [47:32] t0_speed_cms,
    //          [63:48] t1_x_mm, [79:64] t1_y_mm, [95:80] t1_speed_cms,
    //          [111:96] t2_x_mm, [127:112] t2_y_mm, [143:128] t2_speed_cms,
    //          [145:144] valid_count, [151:146] zero
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [rtfp_pkg::M_TDATA_W-1:0]          m_tdata
);

    localparam int FRAME_BYTES = TARGET_SLOTS * RECORD_BYTES;
    localparam int STORE_BYTES = FRAME_BYTES - 1;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    // sum is never narrower than the count field
    localparam int SUM_W       = ($clog2(TARGET_SLOTS + 1) > rtfp_pkg::VCNT_W) ?
                                 $clog2(TARGET_SLOTS + 1) : rtfp_pkg::VCNT_W;
    localparam int FW          = rtfp_pkg::FIELD_W;

    logic [rtfp_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [CNT_W-1:0]               pay_cnt_reg, pay_cnt_next;
    logic [7:0]                     store_reg [STORE_BYTES];
    logic [7:0]                     store_next [STORE_BYTES];
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [rtfp_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                           hunting;
    logic                           frame_last;
    logic                           s_accept;
    logic                           hdr_match;
    logic [7:0]                     frame_byte [FRAME_BYTES];
    rtfp_pkg::target_t              target [TARGET_SLOTS];
    logic [TARGET_SLOTS-1:0]        target_ok;
    rtfp_pkg::target_t              out_target [rtfp_pkg::OUT_SLOTS];
    logic [SUM_W-1:0]               ok_sum;
    logic [rtfp_pkg::VCNT_W-1:0]    valid_count;

    // Frame progress
    assign hunting    = (hdr_cnt_reg != rtfp_pkg::HDR_DONE);
    assign frame_last = !hunting && (pay_cnt_reg == CNT_W'(FRAME_BYTES - 1));
    assign hdr_match  = (s_tdata == rtfp_pkg::hdr_byte(hdr_cnt_reg[1:0]));

    // Only the frame-closing byte waits for the output register
    assign s_tready = !(frame_last && m_tvalid_reg && !m_tready);
    assign s_accept = s_tvalid && s_tready;

    // Frame view: stored bytes plus the byte arriving now in the top slot
    genvar k;
    generate
        for (k = 0; k < FRAME_BYTES; k++) begin : g_frame
            if (k < STORE_BYTES) begin : g_stored
                assign frame_byte[k] = store_reg[k];
            end else begin : g_live
                assign frame_byte[k] = s_tdata;
            end
        end
    endgenerate

    // Per-target decode
    genvar s;
    generate
        for (s = 0; s < TARGET_SLOTS; s++) begin : g_slot
            rtfp_target_decode u_dec (
                .x_raw     ({frame_byte[s*RECORD_BYTES + 1], frame_byte[s*RECORD_BYTES + 0]}),
                .y_raw     ({frame_byte[s*RECORD_BYTES + 3], frame_byte[s*RECORD_BYTES + 2]}),
                .speed_raw ({frame_byte[s*RECORD_BYTES + 5], frame_byte[s*RECORD_BYTES + 4]}),
                .target    (target[s]),
                .ok        (target_ok[s])
            );
        end
        for (s = 0; s < rtfp_pkg::OUT_SLOTS; s++) begin : g_out
            if (s < TARGET_SLOTS) begin : g_used
                assign out_target[s] = target[s];
            end else begin : g_empty
                assign out_target[s] = '0;
            end
        end
    endgenerate

    // Valid target count, saturated to the field width
    always_comb begin
        ok_sum = '0;
        for (int i = 0; i < TARGET_SLOTS; i++) begin
            ok_sum = ok_sum + SUM_W'(target_ok[i]);
        end
        if (ok_sum > SUM_W'(3)) begin
            valid_count = 2'd3;
        end else begin
            valid_count = ok_sum[rtfp_pkg::VCNT_W-1:0];
        end
    end

    // Result word packing
    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < rtfp_pkg::OUT_SLOTS; i++) begin
            m_tdata_next[i*rtfp_pkg::SLOT_W +: FW]          = out_target[i].x;
            m_tdata_next[i*rtfp_pkg::SLOT_W + FW +: FW]     = out_target[i].y;
            m_tdata_next[i*rtfp_pkg::SLOT_W + 2*FW +: FW]   = out_target[i].speed;
        end
        m_tdata_next[rtfp_pkg::VCNT_OFS +: rtfp_pkg::VCNT_W] = valid_count;
    end

    // Payload shift line
    always_comb begin
        for (int i = 0; i < STORE_BYTES - 1; i++) begin
            store_next[i] = store_reg[i+1];
        end
        store_next[STORE_BYTES-1] = s_tdata;
    end

    // Counter and output-valid updates
    always_comb begin
        hdr_cnt_next  = hdr_cnt_reg;
        pay_cnt_next  = pay_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (s_accept) begin
            priority if (hunting) begin
                hdr_cnt_next = hdr_match ? hdr_cnt_reg + 1'b1 : '0;
            end else if (frame_last) begin
                hdr_cnt_next  = '0;
                pay_cnt_next  = '0;
                m_tvalid_next = 1'b1;
            end else begin
                pay_cnt_next = pay_cnt_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg  <= '0;
            pay_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            hdr_cnt_reg  <= hdr_cnt_next;
            pay_cnt_reg  <= pay_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and result registers
    always_ff @(posedge aclk) begin
        if (s_accept && !hunting && !frame_last) begin
            store_reg <= store_next;
        end
        if (s_accept && frame_last) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- design/rtfp_checker.sv -----
// Port-level checks of the radar target frame parser, bound to the top level.
`default_nettype none

`include "radar_target_frame_parser_macros.svh"

module rtfp_checker #(
    parameter int TARGET_SLOTS = 3
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [rtfp_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rtfp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int MAX_VALID = (TARGET_SLOTS > 3) ? 3 : TARGET_SLOTS;
    localparam int PAD_W     = rtfp_pkg::M_TDATA_W - rtfp_pkg::VCNT_OFS - rtfp_pkg::VCNT_W;

    logic                              s_accept;
    logic                              m_stall;
    logic [rtfp_pkg::VCNT_W-1:0]       vcnt;
    logic [PAD_W-1:0]                  pad;
    logic [7:0]                        in_byte;

    assign s_accept = s_tvalid && s_tready;
    assign m_stall  = m_tvalid && !m_tready;
    assign vcnt     = m_tdata[rtfp_pkg::VCNT_OFS +: rtfp_pkg::VCNT_W];
    assign pad      = m_tdata[rtfp_pkg::M_TDATA_W-1 -: PAD_W];
    assign in_byte  = s_tdata;

    // A stalled result holds
    `RTFP_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A new result follows an accepted byte
    `RTFP_ASSERT_NOW(a_cause, aclk, aresetn, $rose(m_tvalid), $past(s_accept) && ($past(in_byte) == $past(s_tdata)), "result without input byte")

    // Valid count bounded by the slots present, and padding zero
    `RTFP_ASSERT_NOW(a_vcnt, aclk, aresetn, m_tvalid, (32'(vcnt) <= MAX_VALID) && (pad == '0), "bad valid count or padding")

    // Input is never refused while the output side is free
    `RTFP_ASSERT_NOW(a_ready, aclk, aresetn, !m_tvalid, s_tready, "input refused with output empty")

endmodule

bind radar_target_frame_parser rtfp_checker #(
    .TARGET_SLOTS (TARGET_SLOTS)
) u_rtfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- bench/radar_frame_checker.sv -----
`timescale 1ns / 1ps
// Checker for the radar target frame parser: frame predictor and result scoreboard.
module radar_frame_checker
    import rtfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   pending,
    output int                   frames_checked
);

    localparam int SLOTS      = 3;
    localparam int REC_BYTES  = 8;
    localparam int FRAME_LEN  = SLOTS * REC_BYTES;
    localparam int NUM_FIELDS = 11;
    localparam int MAX_REPORT = 10;
    localparam logic [7:0] SYNC [HDR_LEN] = '{8'hAA, 8'hFF, 8'h03, 8'h00};

    // Names of the result fields, lowest bits first; the last one is the pad
    string field_name [NUM_FIELDS] = '{
        "t0_x_mm", "t0_y_mm", "t0_speed_cms",
        "t1_x_mm", "t1_y_mm", "t1_speed_cms",
        "t2_x_mm", "t2_y_mm", "t2_speed_cms",
        "valid_count", "pad"
    };

    // Predictor state
    logic [HDR_CNT_W-1:0]  hdr_matched;
    logic [4:0]            bytes_got;
    logic [7:0]            payload [FRAME_LEN];
    logic [M_TDATA_W-1:0]  frames_due [$];

    // Sign-magnitude word to two's complement; bit 15 set means positive
    function automatic logic [FIELD_W-1:0] sm_to_twos(input logic [FIELD_W-1:0] raw);
        logic [FIELD_W-1:0] mag;
        mag = {1'b0, raw[FIELD_W-2:0]};
        return raw[FIELD_W-1] ? mag : 16'h0000 - mag;
    endfunction

    // Little-endian word out of the captured payload
    function automatic logic [FIELD_W-1:0] payload_word(input int pos);
        return {payload[pos + 1], payload[pos]};
    endfunction

    // One field of a packed result, zero-extended to 16 bits
    function automatic logic [FIELD_W-1:0] field_of(input logic [M_TDATA_W-1:0] v,
                                                    input int f);
        if (f < 3 * SLOTS)
            return v[f*FIELD_W +: FIELD_W];
        else if (f == 3 * SLOTS)
            return 16'(v[VCNT_OFS +: VCNT_W]);
        else
            return 16'(v[M_TDATA_W-1:VCNT_OFS+VCNT_W]);
    endfunction

    // Advance the parser by one byte; queue a decoded frame on the last payload byte
    task automatic absorb_byte(input logic [7:0] b);
        logic [M_TDATA_W-1:0] frame;
        logic [FIELD_W-1:0]   x, y, v;
        int                   valid, base;
        if (hdr_matched < HDR_DONE) begin
            // a mismatch clears the hunt and the byte is not retried
            if (b == SYNC[hdr_matched[1:0]])
                hdr_matched = hdr_matched + 1'b1;
            else
                hdr_matched = '0;
        end else begin
            payload[bytes_got] = b;
            if (bytes_got != FRAME_LEN - 1) begin
                bytes_got = bytes_got + 1'b1;
            end else begin
                frame = '0;
                valid = 0;
                for (int s = 0; s < SLOTS; s++) begin
                    base = s * REC_BYTES;
                    x = payload_word(base);
                    y = payload_word(base + 2);
                    v = payload_word(base + 4);
                    // a target with zero x or y is passed through raw
                    if (x != 0 && y != 0) begin
                        valid++;
                        x = sm_to_twos(x);
                        y = sm_to_twos(y);
                        v = sm_to_twos(v);
                    end
                    frame[(3*s)*FIELD_W     +: FIELD_W] = x;
                    frame[(3*s + 1)*FIELD_W +: FIELD_W] = y;
                    frame[(3*s + 2)*FIELD_W +: FIELD_W] = v;
                end
                frame[VCNT_OFS +: VCNT_W] = (valid > 3) ? 2'd3 : VCNT_W'(valid);
                frames_due.push_back(frame);
                hdr_matched = '0;
                bytes_got   = '0;
            end
        end
    endtask

    // Compare one result item with the oldest decoded frame
    task automatic check_frame(input logic [M_TDATA_W-1:0] got);
        logic [M_TDATA_W-1:0] want;
        frames_checked++;
        if (frames_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORT)
                $display("[%0t] result item with no frame pending: %h", $realtime, got);
        end else begin
            want = frames_due.pop_front();
            for (int f = 0; f < NUM_FIELDS; f++) begin
                if (field_of(got, f) !== field_of(want, f)) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                        $display("[%0t] frame %0d %s: expected %h, got %h", $realtime,
                                 frames_checked, field_name[f], field_of(want, f),
                                 field_of(got, f));
                end
            end
        end
    endtask

    // Watch both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr_matched    = '0;
            bytes_got      = '0;
            fail_count     = 0;
            frames_checked = 0;
            frames_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata[7:0]);
            if (m_tvalid && m_tready)
                check_frame(m_tdata);
        end
        pending = frames_due.size();
    end

endmodule

// ----- bench/tb_radar_target_frame_parser.sv -----
`timescale 1ns / 1ps
// Testbench top for the radar target frame parser: stimulus, idling and verdict.
module tb_radar_target_frame_parser;
    import rtfp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 1300;
    localparam int QUIET_FROM  = 1150;
    localparam int DRAIN_EVERY = 400;
    localparam logic [7:0] SYNC [HDR_LEN] = '{8'hAA, 8'hFF, 8'h03, 8'h00};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int frames_pending;
    int frames_checked;
    int bytes_sent;
    int frames_sent;
    int rx_stall_left;
    int idle_cycles;
    bit idle_phase;
    bit quiet;

    // 50 MHz clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    radar_target_frame_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    radar_frame_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (frames_pending),
        .frames_checked (frames_checked)
    );

    // Result side backpressure in random bursts, only in idle phases before the quiet tail
    always @(negedge aclk) begin
        if (rx_stall_left != 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else if (idle_phase && !quiet && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_stall_left = $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("radar_target_frame_parser verification failed");
                $finish;
            end
        end
    end

    // Offer one byte, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge aclk);
        if (idle_phase && !quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Header plus three 8-byte records; word k sits at words[16k +: 16]
    task automatic send_frame(input logic [12*FIELD_W-1:0] words);
        for (int i = 0; i < HDR_LEN; i++)
            send_byte(SYNC[i]);
        for (int k = 0; k < 12; k++) begin
            send_byte(words[k*FIELD_W +: 8]);
            send_byte(words[k*FIELD_W + 8 +: 8]);
        end
        frames_sent++;
    endtask

    // Hold the input off until every decoded frame has been taken
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frames_pending != 0) @(negedge aclk);
    endtask

    // Payload word biased toward zero, the sign bit and magnitude extremes
    function automatic logic [FIELD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [12*FIELD_W-1:0] words;
        logic [7:0]            bad;
        int                    n;
        int                    next_drain;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        rx_stall_left = 0;
        idle_cycles   = 0;
        bytes_sent    = 0;
        frames_sent   = 0;
        idle_phase    = 1'b0;
        quiet         = 1'b0;
        next_drain    = DRAIN_EVERY;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // broken header, then a repeated first byte that must not restart the hunt
        send_byte(8'hAA);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'hAA);
        // t0 valid with +0 x and -0 speed, t1 invalid (x zero), t2 valid extremes
        words = {16'h1234, 16'hFFFF, 16'h0001, 16'h7FFF,
                 16'h0000, 16'h8001, 16'h7FFF, 16'h0000,
                 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000};
        send_frame(words);
        drain_results();

        // random mix of frames, broken headers and line noise
        while (bytes_sent < ITEM_TARGET) begin
            quiet      = (bytes_sent >= QUIET_FROM);
            idle_phase = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19)) inside
                [0:13]: begin
                    for (int k = 0; k < 12; k++)
                        words[k*FIELD_W +: FIELD_W] = pick_word();
                    send_frame(words);
                end
                [14:16]: begin
                    n = $urandom_range(1, HDR_LEN - 1);
                    for (int i = 0; i < n; i++)
                        send_byte(SYNC[i]);
                    do bad = 8'($urandom); while (bad == SYNC[n]);
                    send_byte(bad);
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_byte(8'($urandom));
                end
            endcase
            if (bytes_sent >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
        end

        // wind down
        drain_results();
        repeat (10) @(posedge aclk);
        $display("Sent %0d bytes holding %0d well-formed frames among broken headers and noise,",
                 bytes_sent, frames_sent);
        $display("with random idling on both sides; %0d decoded frames compared.",
                 frames_checked);
        if (fail_count == 0 && frames_pending == 0) begin
            $display("radar_target_frame_parser verification clean");
        end else begin
            $display("radar_target_frame_parser verification failed");
        end
        $finish;
    end

endmodule
